@@ rtl/dms_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dms_pkg: shared types and constants
// Digit width, operand depth, front queue depth and the entry that the front
// hands to the back.
// ----------------------------------------------------------------------------
package dms_pkg;

	localparam int MAX_DIGITS = 64;
	localparam int DIGIT_W    = 4;
	localparam int QDEPTH     = 2;
	localparam int QAW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	localparam logic [1:0] KIND_A      = 2'd0;
	localparam logic [1:0] KIND_B      = 2'd1;
	localparam logic [1:0] KIND_B_LAST = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [DIGIT_W-1:0] digit;
	} dms_entry_t;

endpackage
`default_nettype wire

@@ rtl/dms_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dms_front: input stage
// Takes digit beats, clamps the digit, tags each beat as an A digit, a B
// digit or the final B digit, and buffers it in a short queue for the back.
// ----------------------------------------------------------------------------
module dms_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  push,
	output logic                                 full,
	input  wire                                  op,
	input  wire  [dms_pkg::DIGIT_W-1:0]          digit,
	input  wire                                  last,
	output logic                                 q_valid,
	output dms_pkg::dms_entry_t                  q_entry,
	input  wire                                  q_ready
);

	dms_pkg::dms_entry_t            slot_q [dms_pkg::QDEPTH];
	logic [dms_pkg::QAW-1:0]        wr_ptr_q;
	logic [dms_pkg::QAW-1:0]        rd_ptr_q;
	logic [dms_pkg::QAW:0]          count_q;
	dms_pkg::dms_entry_t            new_entry;
	logic                           do_push;
	logic                           do_pop;

	always_comb begin
		new_entry.digit = (digit > dms_pkg::DIGIT_MAX) ? dms_pkg::DIGIT_MAX : digit;
		if (!op) begin
			new_entry.kind = dms_pkg::KIND_A;
		end else if (last) begin
			new_entry.kind = dms_pkg::KIND_B_LAST;
		end else begin
			new_entry.kind = dms_pkg::KIND_B;
		end
	end

	assign full    = (count_q == (dms_pkg::QAW+1)'(dms_pkg::QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_entry = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/dms_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dms_back: digit store and subtract sequencer
// Stores operand digits, then compares from the top, subtracts with decimal
// borrow from the bottom, and emits the difference from its top nonzero digit.
// ----------------------------------------------------------------------------
module dms_back #(
	parameter int MaxDigits = dms_pkg::MAX_DIGITS
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  q_valid,
	input  wire dms_pkg::dms_entry_t             q_entry,
	output logic                                 q_ready,
	output logic                                 empty,
	input  wire                                  pop,
	output logic [dms_pkg::DIGIT_W-1:0]          result_digit,
	output logic                                 result_last
);

	localparam int LW = $clog2(MaxDigits + 1);
	localparam int AW = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
	localparam int DW = dms_pkg::DIGIT_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SETUP   = 3'd1;
	localparam logic [2:0] ST_CMP_RD  = 3'd2;
	localparam logic [2:0] ST_CMP_EV  = 3'd3;
	localparam logic [2:0] ST_SUB_RD  = 3'd4;
	localparam logic [2:0] ST_SUB_EV  = 3'd5;
	localparam logic [2:0] ST_EMIT_RD = 3'd6;
	localparam logic [2:0] ST_EMIT_EV = 3'd7;

	logic [DW-1:0] mem_a [MaxDigits];
	logic [DW-1:0] mem_b [MaxDigits];
	logic [DW-1:0] mem_d [MaxDigits];

	logic [2:0]    state_q;
	logic [LW-1:0] len_a_q;
	logic [LW-1:0] len_b_q;
	logic          out_valid_q;
	logic [DW-1:0] out_digit_q;
	logic          out_last_q;

	logic [LW-1:0] n_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] top_q;
	logic          b_larger_q;
	logic          borrow_q;
	logic          zero_q;
	logic          in_a_q;
	logic          in_b_q;
	logic [DW-1:0] rd_a_q;
	logic [DW-1:0] rd_b_q;
	logic [DW-1:0] rd_d_q;

	logic          take;
	logic          wr_a;
	logic          wr_b;
	logic          wr_d;
	logic [LW-1:0] off_a;
	logic [LW-1:0] off_b;
	logic [LW-1:0] n_max;
	logic [DW-1:0] da;
	logic [DW-1:0] db;
	logic [DW:0]   x5;
	logic [DW:0]   y5;
	logic [DW:0]   d5;
	logic [DW-1:0] diff;
	logic          out_free;
	logic          sub_done;
	logic          emit;

	assign q_ready  = (state_q == ST_IDLE);
	assign take     = q_valid && q_ready;
	assign wr_a     = take && (q_entry.kind == dms_pkg::KIND_A) && (len_a_q < LW'(MaxDigits));
	assign wr_b     = take && (q_entry.kind != dms_pkg::KIND_A) && (len_b_q < LW'(MaxDigits));
	assign wr_d     = (state_q == ST_SUB_EV);
	assign off_a    = len_a_q - LW'(1) - LW'(pos_q);
	assign off_b    = len_b_q - LW'(1) - LW'(pos_q);
	assign n_max    = (len_a_q > len_b_q) ? len_a_q : len_b_q;
	assign da       = in_a_q ? rd_a_q : '0;
	assign db       = in_b_q ? rd_b_q : '0;
	assign x5       = {1'b0, (b_larger_q ? db : da)};
	assign y5       = {1'b0, (b_larger_q ? da : db)} + (DW+1)'(borrow_q);
	assign d5       = (x5 < y5) ? (x5 + (DW+1)'(10) - y5) : (x5 - y5);
	assign diff     = d5[DW-1:0];
	assign out_free = !out_valid_q || pop;
	assign sub_done = (LW'(pos_q) == n_q - LW'(1));
	assign emit     = (state_q == ST_EMIT_EV) && out_free;

	assign empty        = !out_valid_q;
	assign result_digit = out_digit_q;
	assign result_last  = out_last_q;

	// digit stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[len_a_q[AW-1:0]] <= q_entry.digit;
		end
		rd_a_q <= mem_a[off_a[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[len_b_q[AW-1:0]] <= q_entry.digit;
		end
		rd_b_q <= mem_b[off_b[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_d) begin
			mem_d[pos_q] <= diff;
		end
		rd_d_q <= mem_d[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_a_q     <= '0;
			len_b_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (wr_a) begin
						len_a_q <= len_a_q + LW'(1);
					end
					if (wr_b) begin
						len_b_q <= len_b_q + LW'(1);
					end
					if (take && (q_entry.kind == dms_pkg::KIND_B_LAST)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= (n_max == '0) ? ST_EMIT_EV : ST_CMP_RD;
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_EV;
				end
				ST_CMP_EV: begin
					if ((da != db) || (pos_q == '0)) begin
						state_q <= ST_SUB_RD;
					end else begin
						state_q <= ST_CMP_RD;
					end
				end
				ST_SUB_RD: begin
					state_q <= ST_SUB_EV;
				end
				ST_SUB_EV: begin
					state_q <= sub_done ? ST_EMIT_RD : ST_SUB_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_EV;
				end
				ST_EMIT_EV: begin
					if (out_free) begin
						if (zero_q || (pos_q == '0)) begin
							len_a_q <= '0;
							len_b_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETUP: begin
				n_q        <= n_max;
				pos_q      <= AW'(n_max - LW'(1));
				zero_q     <= (n_max == '0);
				b_larger_q <= 1'b0;
			end
			ST_CMP_RD: begin
				in_a_q <= (LW'(pos_q) < len_a_q);
				in_b_q <= (LW'(pos_q) < len_b_q);
			end
			ST_CMP_EV: begin
				if ((da != db) || (pos_q == '0)) begin
					b_larger_q <= (db > da);
					pos_q      <= '0;
					borrow_q   <= 1'b0;
					top_q      <= '0;
				end else begin
					pos_q <= pos_q - AW'(1);
				end
			end
			ST_SUB_RD: begin
				in_a_q <= (LW'(pos_q) < len_a_q);
				in_b_q <= (LW'(pos_q) < len_b_q);
			end
			ST_SUB_EV: begin
				borrow_q <= (x5 < y5);
				if (diff != '0) begin
					top_q <= pos_q;
				end
				if (sub_done) begin
					pos_q <= (diff != '0) ? pos_q : top_q;
				end else begin
					pos_q <= pos_q + AW'(1);
				end
			end
			ST_EMIT_EV: begin
				if (out_free) begin
					out_digit_q <= zero_q ? '0 : rd_d_q;
					out_last_q  <= zero_q || (pos_q == '0);
					if (!zero_q && (pos_q != '0)) begin
						pos_q <= pos_q - AW'(1);
					end
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/decimal_magnitude_subtractor_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_magnitude_subtractor_top: |A - B| of two decimal numbers
// Input beats (push/full) carry op, digit and last. Send all digits of A
// (op = 0), most significant first, then all digits of B (op = 1); the B
// beat with last = 1 starts the computation. Digits above nine are taken as
// nine; digits beyond MaxDigits per operand are dropped.
// Result beats (empty/pop) carry result_digit and result_last, most
// significant digit first, no leading zeros, at least one digit.
// Loading takes one beat per cycle while not full. After the last B beat the
// sequencer runs a setup step, compares digits from the top (up to n), then
// subtracts n digits from the bottom (n = longer operand length) and emits
// the result digits; each phase reads one digit at a time through the
// registered reads of the digit stores, in a read state and an evaluate state.
// Input beats keep queuing (two deep) while the block computes, then full.
// When pop is held low the sequencer waits with the next digit; nothing is
// lost. Reset empties the queue, clears the operand lengths and the result.
// ----------------------------------------------------------------------------
module decimal_magnitude_subtractor_top #(
	parameter int MaxDigits = dms_pkg::MAX_DIGITS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	output logic                        full,
	input  wire                         op,
	input  wire  [dms_pkg::DIGIT_W-1:0] digit,
	input  wire                         last,
	output logic                        empty,
	input  wire                         pop,
	output logic [dms_pkg::DIGIT_W-1:0] result_digit,
	output logic                        result_last
);

	logic                q_valid;
	logic                q_ready;
	dms_pkg::dms_entry_t q_entry;

	dms_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.op      (op),
		.digit   (digit),
		.last    (last),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_ready (q_ready)
	);

	dms_back #(
		.MaxDigits (MaxDigits)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.q_ready      (q_ready),
		.empty        (empty),
		.pop          (pop),
		.result_digit (result_digit),
		.result_last  (result_last)
	);

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && (q_entry.kind == dms_pkg::KIND_B_LAST)) |=> !q_ready)
		else $error("sequencer did not start after final B digit");

	a_queue_digit: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (q_entry.digit <= dms_pkg::DIGIT_MAX))
		else $error("queued digit not clamped");

	a_result_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !q_ready) |-> (result_digit <= dms_pkg::DIGIT_MAX))
		else $error("result digit out of range");
`endif

endmodule
`default_nettype wire

@@ bench/decimal_magnitude_subtractor_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_magnitude_subtractor_checker: difference predictor and scoreboard
// Watches the digit input queue and the result queue of the subtractor. Keeps
// its own copy of both operands, works out |A - B| digit by digit when the
// final B digit is taken and compares every result beat with the oldest
// expected difference digit.
// ----------------------------------------------------------------------------
module decimal_magnitude_subtractor_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	input  wire                         full,
	input  wire                         op,
	input  wire  [dms_pkg::DIGIT_W-1:0] digit,
	input  wire                         last,
	input  wire                         empty,
	input  wire                         pop,
	input  wire  [dms_pkg::DIGIT_W-1:0] result_digit,
	input  wire                         result_last,
	output int                          error_count,
	output int                          pending_beats
);

	typedef struct packed {
		logic [dms_pkg::DIGIT_W-1:0] digit;
		logic                        last;
	} diff_beat_t;

	logic [dms_pkg::DIGIT_W-1:0] a_digits [dms_pkg::MAX_DIGITS];
	logic [dms_pkg::DIGIT_W-1:0] b_digits [dms_pkg::MAX_DIGITS];
	logic [6:0]                  a_len;
	logic [6:0]                  b_len;
	diff_beat_t                  diff_q [$];

	initial error_count = 0;

	// digit of weight 10^pos, zero above the stored length
	function automatic int digit_of(input bit from_b, input int pos);
		int len;
		len = from_b ? int'(b_len) : int'(a_len);
		if (pos >= len)
			return 0;
		return from_b ? int'(b_digits[len-1-pos]) : int'(a_digits[len-1-pos]);
	endfunction

	task automatic subtract_operands();
		int         n;
		int         i;
		int         x;
		int         y;
		int         borrow;
		int         top;
		bit         b_wins;
		bit         decided;
		int         diff [dms_pkg::MAX_DIGITS];
		diff_beat_t beat;
		n = (a_len > b_len) ? int'(a_len) : int'(b_len);
		b_wins = 1'b0;
		decided = 1'b0;
		borrow = 0;
		top = -1;
		for (i = n - 1; i >= 0; i--) begin
			if (!decided && digit_of(1'b0, i) != digit_of(1'b1, i)) begin
				decided = 1'b1;
				b_wins = digit_of(1'b1, i) > digit_of(1'b0, i);
			end
		end
		for (i = 0; i < dms_pkg::MAX_DIGITS; i++)
			diff[i] = 0;
		for (i = 0; i < n; i++) begin
			x = digit_of(b_wins, i);
			y = digit_of(!b_wins, i) + borrow;
			if (x < y) begin
				diff[i] = x + 10 - y;
				borrow = 1;
			end else begin
				diff[i] = x - y;
				borrow = 0;
			end
		end
		for (i = n - 1; i >= 0; i--)
			if (top < 0 && diff[i] != 0)
				top = i;
		if (top < 0)
			top = 0;
		for (i = top; i >= 0; i--) begin
			beat.digit = diff[i][dms_pkg::DIGIT_W-1:0];
			beat.last = (i == 0);
			diff_q.push_back(beat);
		end
		a_len = '0;
		b_len = '0;
	endtask

	task automatic absorb_digit(input logic is_b, input logic [dms_pkg::DIGIT_W-1:0] d,
			input logic ends);
		logic [dms_pkg::DIGIT_W-1:0] kept;
		kept = (d > dms_pkg::DIGIT_MAX) ? dms_pkg::DIGIT_MAX : d;
		if (!is_b) begin
			if (a_len < dms_pkg::MAX_DIGITS) begin
				a_digits[a_len] = kept;
				a_len++;
			end
		end else begin
			if (b_len < dms_pkg::MAX_DIGITS) begin
				b_digits[b_len] = kept;
				b_len++;
			end
			if (ends)
				subtract_operands();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		diff_beat_t want;
		if (!arst_n) begin
			a_len = '0;
			b_len = '0;
			diff_q.delete();
			pending_beats <= 0;
		end else begin
			if (pop && !empty) begin
				if (diff_q.size() == 0) begin
					$display("%0t: unexpected result beat: expected none, actual digit %0d last %0d",
						$time, result_digit, result_last);
					error_count++;
				end else begin
					want = diff_q.pop_front();
					if (result_digit !== want.digit) begin
						$display("%0t: result_digit mismatch: expected %0d, actual %0d",
							$time, want.digit, result_digit);
						error_count++;
					end
					if (result_last !== want.last) begin
						$display("%0t: result_last mismatch: expected %0d, actual %0d",
							$time, want.last, result_last);
						error_count++;
					end
				end
			end
			if (push && !full)
				absorb_digit(op, digit, last);
			pending_beats <= diff_q.size();
		end
	end

endmodule

@@ bench/decimal_magnitude_subtractor_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_magnitude_subtractor_top_tb: testbench of the decimal subtractor
// Sends directed operand pairs (equal numbers, empty A, interleaved digits,
// leading zeros, digits above nine, long borrows), then random pairs with
// some overlong operands and noise, in bursts with gaps, while the result
// side stalls on its own pattern. The checker predicts and compares.
// ----------------------------------------------------------------------------
module decimal_magnitude_subtractor_top_tb;

	localparam int RANDOM_ITEMS  = 190;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 500;
	localparam int CYCLE_LIMIT   = 400000;

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic                        op;
	logic [dms_pkg::DIGIT_W-1:0] digit;
	logic                        last;
	logic                        empty;
	logic                        pop;
	logic [dms_pkg::DIGIT_W-1:0] result_digit;
	logic                        result_last;

	int                          error_count;
	int                          pending_beats;
	int                          burst_left;
	int                          items_sent;
	int                          cycles;
	bit                          hold_req = 1'b0;
	logic [dms_pkg::DIGIT_W-1:0] a_copy [$];

	decimal_magnitude_subtractor_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.op          (op),
		.digit       (digit),
		.last        (last),
		.empty       (empty),
		.pop         (pop),
		.result_digit(result_digit),
		.result_last (result_last)
	);

	decimal_magnitude_subtractor_checker diff_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.digit        (digit),
		.last         (last),
		.empty        (empty),
		.pop          (pop),
		.result_digit (result_digit),
		.result_last  (result_last),
		.error_count  (error_count),
		.pending_beats(pending_beats)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [dms_pkg::DIGIT_W-1:0] rand_digit();
		if ($urandom_range(0, 9) == 0)
			return dms_pkg::DIGIT_W'($urandom_range(10, 15));
		return dms_pkg::DIGIT_W'($urandom_range(0, 9));
	endfunction

	function automatic int pick_len(input int low);
		if ($urandom_range(0, 24) == 0)
			return $urandom_range(60, 70);
		return $urandom_range(low, 8);
	endfunction

	task automatic send_beat(input logic o, input logic [dms_pkg::DIGIT_W-1:0] d,
			input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0)
				push <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		push <= 1'b1;
		op <= o;
		digit <= d;
		last <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_operand(input logic is_b, input int len, input logic mark_end);
		int                          i;
		logic [dms_pkg::DIGIT_W-1:0] d;
		if (!is_b)
			a_copy.delete();
		for (i = 0; i < len; i++) begin
			d = rand_digit();
			if (!is_b)
				a_copy.push_back(d);
			send_beat(is_b, d, mark_end && (i == len - 1));
		end
	endtask

	// sender idles until every expected beat is back
	task automatic drain();
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
	endtask

	// result side: stall pattern, plus one long hold-off on request
	initial begin
		int mode;
		int span;
		bit take;
		pop <= 1'b0;
		mode = 0;
		span = 0;
		take = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 80);
			end
			span--;
			case (mode)
				0: take = 1'b1;
				1: take = ($urandom_range(0, 3) != 0);
				2: take = ($urandom_range(0, 3) == 0);
				default: take = ~take;
			endcase
			pop <= take;
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int                          goal;
		int                          mid;
		int                          la;
		int                          i;
		bit                          paused;
		logic [dms_pkg::DIGIT_W-1:0] d;
		arst_n <= 1'b0;
		push <= 1'b0;
		op <= 1'b0;
		digit <= '0;
		last <= 1'b0;
		burst_left = 0;
		items_sent = 0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// equal numbers, last flag on A ignored
		send_beat(1'b0, 4'd9, 1'b1);
		send_beat(1'b1, 4'd9, 1'b1);
		// empty A
		send_beat(1'b1, 4'd5, 1'b1);
		// A digit between B digits
		send_beat(1'b0, 4'd3, 1'b0);
		send_beat(1'b1, 4'd1, 1'b0);
		send_beat(1'b0, 4'd4, 1'b0);
		send_beat(1'b1, 4'd2, 1'b1);
		// leading zeros in A, B larger
		send_beat(1'b0, 4'd0, 1'b0);
		send_beat(1'b0, 4'd0, 1'b0);
		send_beat(1'b0, 4'd5, 1'b0);
		send_beat(1'b1, 4'd1, 1'b0);
		send_beat(1'b1, 4'd2, 1'b1);
		// digits above nine
		send_beat(1'b0, 4'd1, 1'b0);
		send_beat(1'b0, 4'd15, 1'b0);
		send_beat(1'b1, 4'd12, 1'b1);
		// borrow through zeros
		send_beat(1'b0, 4'd1, 1'b0);
		send_beat(1'b1, 4'd1, 1'b0);
		send_beat(1'b1, 4'd0, 1'b0);
		send_beat(1'b1, 4'd0, 1'b1);
		// zero minus zero
		send_beat(1'b0, 4'd0, 1'b0);
		send_beat(1'b1, 4'd0, 1'b1);
		drain();

		goal = items_sent + RANDOM_ITEMS;
		mid = items_sent + RANDOM_ITEMS / 2;
		hold_req = 1'b1;
		while (items_sent < goal) begin
			if (!paused && items_sent >= mid) begin
				drain();
				paused = 1'b1;
			end
			case ($urandom_range(0, 9))
				0: send_beat(1'($urandom_range(0, 1)), rand_digit(),
					1'($urandom_range(0, 1)));
				1: begin
					send_operand(1'b0, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
					send_operand(1'b1, $urandom_range(1, 3), 1'b0);
				end
				2, 3: begin
					// B equal to A or off in the final digit
					la = $urandom_range(1, 6);
					send_operand(1'b0, la, 1'b0);
					for (i = 0; i < la; i++) begin
						d = a_copy[i];
						if (i == la - 1 && $urandom_range(0, 1))
							d = rand_digit();
						send_beat(1'b1, d, i == la - 1);
					end
				end
				default: begin
					send_operand(1'b0, pick_len(0), 1'($urandom_range(0, 1)));
					send_operand(1'b1, pick_len(1), 1'b1);
				end
			endcase
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_beats == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
